// ===== design/bfha_pkg.sv =====
// shared types, widths and codes for the best-fit heap allocator
package bfha_pkg;

	localparam int ALIGN_DEF   = 8;
	localparam int HEADER_DEF  = 16;
	localparam int GRANULE_DEF = 8192;

	localparam int DATA_W = 32;
	localparam int REQ_W  = 17;
	localparam int SZ_W   = 16;
	localparam int IDX_W  = 18;
	localparam int REM_W  = 5;

	localparam logic REG_HEAP_BASE  = 1'b0;
	localparam logic REG_HEAP_BYTES = 1'b1;

	localparam logic [2:0] ST_ALLOC   = 3'd0;
	localparam logic [2:0] ST_BADSIZE = 3'd1;
	localparam logic [2:0] ST_NOFIT   = 3'd2;
	localparam logic [2:0] ST_FREED   = 3'd3;
	localparam logic [2:0] ST_BADFREE = 3'd4;

	typedef struct packed {
		logic              done;
		logic [DATA_W-1:0] quot;
		logic [REM_W-1:0]  rem;
	} div_res_t;

endpackage

// ===== design/bfha_ram.sv =====
// generic single-port ram with registered read
module bfha_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// ===== design/bfha_div.sv =====
// divide and remainder by the power-of-two alignment constant, registered
module bfha_div #(
	parameter int ALIGN_BYTES = bfha_pkg::ALIGN_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [bfha_pkg::DATA_W-1:0] arg,
	output bfha_pkg::div_res_t          res
);

	localparam int SH = $clog2(ALIGN_BYTES);

	logic [bfha_pkg::DATA_W-1:0] quot_q;
	logic [SH-1:0]               rem_q;
	logic                        done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= arg >> SH;
			rem_q  <= arg[SH-1:0];
		end
	end

	assign res.done = done_q;
	assign res.quot = quot_q;
	assign res.rem  = bfha_pkg::REM_W'(rem_q);

endmodule

// ===== design/best_fit_heap_allocator.sv =====
// best-fit heap allocator top level: sequencer, block tables and result register
//
// one input transaction per request: action 0 allocates request_bytes, action 1
// frees release_address. every accepted transaction gives exactly one result
// transaction with status, payload_address and granted_bytes.
// in_stall is high while a request is in work; the block holds one request at
// a time. an allocate runs the size rounding shift, then walks the block headers
// (a header table read and compare for each block), then ends the walk, updates
// the tables and gives the result. a free runs the address split, then the table
// reads and updates, and then gives the result.
// the result waits in an output register while out_stall is high; the next
// request is taken meanwhile and its result waits until the register drains.
// after reset and after each heap_bytes write the block clears its header and
// free tables, one granule a cycle, with in_stall high. a heap_base write is
// aligned down through the divider, also with in_stall high. configuration writes are
// taken at any time through cfg_we, cfg_index and cfg_data.
module best_fit_heap_allocator #(
	parameter int ALIGN_BYTES  = bfha_pkg::ALIGN_DEF,
	parameter int HEADER_BYTES = bfha_pkg::HEADER_DEF,
	parameter int GRANULES     = bfha_pkg::GRANULE_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [bfha_pkg::DATA_W-1:0] cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        action,
	input  logic [bfha_pkg::REQ_W-1:0]  request_bytes,
	input  logic [bfha_pkg::DATA_W-1:0] release_address,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [2:0]                  status,
	output logic [bfha_pkg::DATA_W-1:0] payload_address,
	output logic [bfha_pkg::REQ_W-1:0]  granted_bytes
);

	localparam int GW       = $clog2(GRANULES);
	localparam int XW       = bfha_pkg::IDX_W;
	localparam int SW       = bfha_pkg::SZ_W;
	localparam int DW       = bfha_pkg::DATA_W;
	localparam int HDRG     = (HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES;
	localparam int HDR_SPAN = HDRG * ALIGN_BYTES;
	localparam int CAPB0    = GRANULES * ALIGN_BYTES;
	localparam int CAPB     = (CAPB0 > 65536) ? 65536 : CAPB0;
	localparam int CAPG     = CAPB / ALIGN_BYTES;
	localparam int MING     = HDRG + 1;

	typedef enum logic [23:0] {
		S_IDLE    = 24'h000001,
		S_BDIV    = 24'h000002,
		S_HDIV    = 24'h000004,
		S_CLR     = 24'h000008,
		S_INIT0   = 24'h000010,
		S_ADIV    = 24'h000020,
		S_WADDR   = 24'h000040,
		S_WDATA   = 24'h000080,
		S_ASEL    = 24'h000100,
		S_AWBEST  = 24'h000200,
		S_ASPLIT  = 24'h000400,
		S_AAFTER  = 24'h000800,
		S_FDIV    = 24'h001000,
		S_FRD     = 24'h002000,
		S_FCHK    = 24'h004000,
		S_NXRD    = 24'h008000,
		S_NXCHK   = 24'h010000,
		S_NXKILL  = 24'h020000,
		S_NXAFTER = 24'h040000,
		S_PVRD    = 24'h080000,
		S_PVCHK   = 24'h100000,
		S_PVKILL  = 24'h200000,
		S_PVAFTER = 24'h400000,
		S_DONE    = 24'h800000
	} state_t;

	state_t st_q;

	logic                    base_pend_q, bytes_pend_q;
	logic [DW-1:0]           base_raw_q;
	logic [bfha_pkg::REQ_W-1:0] bytes_raw_q;
	logic [DW-1:0]           heap_base_q;
	logic [XW-1:0]           heap_gran_q;

	logic                    div_start_q;
	logic [DW-1:0]           div_arg_q;
	bfha_pkg::div_res_t      div_res;

	logic [GW-1:0]           clr_q;
	logic [XW-1:0]           g_q, best_q, bsize_q, al_q, sz_q, sg_q, nx_q, sp_q;
	logic [GW-1:0]           pg_q;
	logic                    found_q, exact_q;

	logic [2:0]              res_status_q;
	logic [DW-1:0]           res_addr_q;
	logic [bfha_pkg::REQ_W-1:0] res_gran_q;

	logic                    out_valid_q;
	logic [2:0]              out_status_q;
	logic [DW-1:0]           out_addr_q;
	logic [bfha_pkg::REQ_W-1:0] out_gran_q;

	logic [GW-1:0]           r_addr;
	logic                    we_hdr, we_free, we_size, we_prev;
	logic                    w_hdr, w_free;
	logic [SW-1:0]           w_size;
	logic [GW-1:0]           w_prev;
	logic                    rd_hdr, rd_free;
	logic [SW-1:0]           rd_size;
	logic [GW-1:0]           rd_prev;

	logic [XW-1:0]           rsz, maxpay, n_idx, after_a, after_n, after_p, wsz;
	logic                    split;

	bfha_div #(.ALIGN_BYTES(ALIGN_BYTES)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.arg    (div_arg_q),
		.res    (div_res)
	);

	bfha_ram #(.WIDTH(1), .DEPTH(GRANULES)) u_hdr (
		.clk(clk), .we(we_hdr), .addr(r_addr), .wdata(w_hdr), .rdata(rd_hdr)
	);
	bfha_ram #(.WIDTH(1), .DEPTH(GRANULES)) u_free (
		.clk(clk), .we(we_free), .addr(r_addr), .wdata(w_free), .rdata(rd_free)
	);
	bfha_ram #(.WIDTH(SW), .DEPTH(GRANULES)) u_size (
		.clk(clk), .we(we_size), .addr(r_addr), .wdata(w_size), .rdata(rd_size)
	);
	bfha_ram #(.WIDTH(GW), .DEPTH(GRANULES)) u_prev (
		.clk(clk), .we(we_prev), .addr(r_addr), .wdata(w_prev), .rdata(rd_prev)
	);

	always_comb begin
		rsz     = XW'(rd_size);
		maxpay  = heap_gran_q - XW'(HDRG);
		n_idx   = best_q + XW'(HDRG) + al_q;
		after_a = best_q + XW'(HDRG) + sz_q;
		after_n = g_q + XW'(HDRG) + sg_q;
		after_p = XW'(pg_q) + XW'(HDRG) + sp_q;
		split   = !exact_q && ((al_q + XW'(HDRG)) < sz_q);
		wsz     = split ? al_q : sz_q;
	end

	always_comb begin
		r_addr  = '0;
		we_hdr  = 1'b0;
		we_free = 1'b0;
		we_size = 1'b0;
		we_prev = 1'b0;
		w_hdr   = 1'b0;
		w_free  = 1'b0;
		w_size  = '0;
		w_prev  = '0;
		unique case (st_q)
			S_CLR: begin
				r_addr  = clr_q;
				we_hdr  = 1'b1;
				we_free = 1'b1;
			end
			S_INIT0: begin
				we_hdr  = 1'b1;
				we_free = 1'b1;
				we_size = 1'b1;
				w_hdr   = 1'b1;
				w_free  = 1'b1;
				w_size  = SW'(maxpay);
			end
			S_WADDR: r_addr = g_q[GW-1:0];
			S_AWBEST: begin
				r_addr  = best_q[GW-1:0];
				we_free = 1'b1;
				we_size = 1'b1;
				w_size  = SW'(wsz);
			end
			S_ASPLIT: begin
				r_addr  = n_idx[GW-1:0];
				we_hdr  = 1'b1;
				we_free = 1'b1;
				we_size = 1'b1;
				we_prev = 1'b1;
				w_hdr   = 1'b1;
				w_free  = 1'b1;
				w_size  = SW'(sz_q - al_q - XW'(HDRG));
				w_prev  = best_q[GW-1:0];
			end
			S_AAFTER: begin
				r_addr  = after_a[GW-1:0];
				we_prev = 1'b1;
				w_prev  = n_idx[GW-1:0];
			end
			S_FRD: r_addr = g_q[GW-1:0];
			S_FCHK: begin
				r_addr  = g_q[GW-1:0];
				we_free = rd_hdr && !rd_free;
				w_free  = 1'b1;
			end
			S_NXRD: r_addr = nx_q[GW-1:0];
			S_NXCHK: begin
				r_addr  = g_q[GW-1:0];
				we_size = rd_free;
				w_size  = SW'(sg_q + rsz + XW'(HDRG));
			end
			S_NXKILL: begin
				r_addr  = nx_q[GW-1:0];
				we_hdr  = 1'b1;
				we_free = 1'b1;
			end
			S_NXAFTER: begin
				r_addr  = after_n[GW-1:0];
				we_prev = 1'b1;
				w_prev  = g_q[GW-1:0];
			end
			S_PVRD: r_addr = pg_q;
			S_PVCHK: begin
				r_addr  = pg_q;
				we_size = rd_free;
				w_size  = SW'(rsz + sg_q + XW'(HDRG));
			end
			S_PVKILL: begin
				r_addr  = g_q[GW-1:0];
				we_hdr  = 1'b1;
				we_free = 1'b1;
			end
			S_PVAFTER: begin
				r_addr  = after_p[GW-1:0];
				we_prev = 1'b1;
				w_prev  = pg_q;
			end
			S_IDLE, S_BDIV, S_HDIV, S_ADIV, S_WDATA, S_ASEL, S_FDIV, S_DONE: begin
				r_addr = g_q[GW-1:0];
			end
			default: r_addr = '0;
		endcase
	end

	assign in_stall = !((st_q == S_IDLE) && !bytes_pend_q && !base_pend_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= S_IDLE;
			base_pend_q  <= 1'b0;
			bytes_pend_q <= 1'b1;
			bytes_raw_q  <= bfha_pkg::REQ_W'(65536);
			base_raw_q   <= '0;
			heap_base_q  <= '0;
			heap_gran_q  <= XW'(CAPG);
			div_start_q  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			div_start_q <= (st_q == S_IDLE) && (bytes_pend_q || base_pend_q || in_valid);
			if (st_q == S_DONE && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				S_IDLE: begin
					if (bytes_pend_q) begin
						div_arg_q <= DW'(bytes_raw_q);
						st_q      <= S_HDIV;
					end else if (base_pend_q) begin
						div_arg_q <= base_raw_q;
						st_q      <= S_BDIV;
					end else if (in_valid) begin
						res_status_q <= bfha_pkg::ST_FREED;
						res_addr_q   <= '0;
						res_gran_q   <= '0;
						if (action) begin
							div_arg_q <= release_address - heap_base_q - DW'(HDR_SPAN);
							st_q      <= S_FDIV;
						end else begin
							div_arg_q <= DW'(request_bytes) + DW'(ALIGN_BYTES - 1);
							st_q      <= S_ADIV;
						end
					end
				end
				S_BDIV: begin
					if (div_res.done) begin
						heap_base_q <= div_arg_q - DW'(div_res.rem);
						st_q        <= S_IDLE;
					end
				end
				S_HDIV: begin
					if (div_res.done) begin
						priority if (div_res.quot > DW'(CAPG)) begin
							heap_gran_q <= XW'(CAPG);
						end else if (div_res.quot < DW'(MING)) begin
							heap_gran_q <= XW'(MING);
						end else begin
							heap_gran_q <= XW'(div_res.quot);
						end
						clr_q <= '0;
						st_q  <= S_CLR;
					end
				end
				S_CLR: begin
					clr_q <= clr_q + GW'(1);
					if (clr_q == GW'(GRANULES - 1)) begin
						st_q <= S_INIT0;
					end
				end
				S_INIT0: st_q <= S_IDLE;
				S_ADIV: begin
					if (div_res.done) begin
						if (div_res.quot == '0 || div_res.quot > DW'(maxpay)) begin
							res_status_q <= bfha_pkg::ST_BADSIZE;
							st_q         <= S_DONE;
						end else begin
							al_q    <= XW'(div_res.quot);
							g_q     <= '0;
							bsize_q <= maxpay;
							found_q <= 1'b0;
							exact_q <= 1'b0;
							st_q    <= S_WADDR;
						end
					end
				end
				S_WADDR: st_q <= (g_q < heap_gran_q) ? S_WDATA : S_ASEL;
				S_WDATA: begin
					priority if (!rd_hdr) begin
						st_q <= S_ASEL;
					end else if (rd_free && rsz == al_q) begin
						best_q  <= g_q;
						exact_q <= 1'b1;
						found_q <= 1'b1;
						st_q    <= S_ASEL;
					end else begin
						if (rd_free && rsz > al_q && rsz <= bsize_q) begin
							best_q  <= g_q;
							bsize_q <= rsz;
							found_q <= 1'b1;
						end
						g_q  <= g_q + XW'(HDRG) + rsz;
						st_q <= S_WADDR;
					end
				end
				S_ASEL: begin
					if (!found_q) begin
						res_status_q <= bfha_pkg::ST_NOFIT;
						st_q         <= S_DONE;
					end else begin
						sz_q <= exact_q ? al_q : bsize_q;
						st_q <= S_AWBEST;
					end
				end
				S_AWBEST: begin
					res_status_q <= bfha_pkg::ST_ALLOC;
					res_addr_q   <= heap_base_q + DW'(best_q) * DW'(ALIGN_BYTES)
						+ DW'(HDR_SPAN);
					res_gran_q   <= bfha_pkg::REQ_W'(DW'(wsz) * DW'(ALIGN_BYTES));
					st_q         <= split ? S_ASPLIT : S_DONE;
				end
				S_ASPLIT: st_q <= (after_a < heap_gran_q) ? S_AAFTER : S_DONE;
				S_AAFTER: st_q <= S_DONE;
				S_FDIV: begin
					if (div_res.done) begin
						if (div_res.rem != '0 || div_res.quot >= DW'(heap_gran_q)) begin
							res_status_q <= bfha_pkg::ST_BADFREE;
							st_q         <= S_DONE;
						end else begin
							g_q  <= XW'(div_res.quot);
							st_q <= S_FRD;
						end
					end
				end
				S_FRD: st_q <= S_FCHK;
				S_FCHK: begin
					if (!rd_hdr || rd_free) begin
						res_status_q <= bfha_pkg::ST_BADFREE;
						st_q         <= S_DONE;
					end else begin
						sg_q <= rsz;
						pg_q <= rd_prev;
						nx_q <= g_q + XW'(HDRG) + rsz;
						st_q <= S_NXRD;
					end
				end
				S_NXRD: st_q <= (nx_q < heap_gran_q) ? S_NXCHK : S_PVRD;
				S_NXCHK: begin
					if (rd_free) begin
						sg_q <= sg_q + rsz + XW'(HDRG);
						st_q <= S_NXKILL;
					end else begin
						st_q <= S_PVRD;
					end
				end
				S_NXKILL: st_q <= (after_n < heap_gran_q) ? S_NXAFTER : S_PVRD;
				S_NXAFTER: st_q <= S_PVRD;
				S_PVRD: st_q <= (g_q != '0) ? S_PVCHK : S_DONE;
				S_PVCHK: begin
					if (rd_free) begin
						sp_q <= rsz + sg_q + XW'(HDRG);
						st_q <= S_PVKILL;
					end else begin
						st_q <= S_DONE;
					end
				end
				S_PVKILL: st_q <= (after_p < heap_gran_q) ? S_PVAFTER : S_DONE;
				S_PVAFTER: st_q <= S_DONE;
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_status_q <= res_status_q;
						out_addr_q   <= res_addr_q;
						out_gran_q   <= res_gran_q;
						st_q         <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
			if (cfg_we && cfg_index == bfha_pkg::REG_HEAP_BYTES) begin
				bytes_pend_q <= 1'b1;
			end else if (st_q == S_IDLE) begin
				bytes_pend_q <= 1'b0;
			end
			if (cfg_we && cfg_index == bfha_pkg::REG_HEAP_BASE) begin
				base_pend_q <= 1'b1;
			end else if (st_q == S_IDLE && !bytes_pend_q) begin
				base_pend_q <= 1'b0;
			end
			if (cfg_we) begin
				if (cfg_index == bfha_pkg::REG_HEAP_BASE) begin
					base_raw_q <= cfg_data;
				end else begin
					bytes_raw_q <= cfg_data[bfha_pkg::REQ_W-1:0];
				end
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = out_status_q;
	assign payload_address = out_addr_q;
	assign granted_bytes   = out_gran_q;

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(st_q == S_DONE))
		else $error("result raised outside completion");

	a_alloc_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q == bfha_pkg::ST_ALLOC) |-> (out_gran_q != '0))
		else $error("allocation granted nothing");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q != bfha_pkg::ST_ALLOC)
		|-> (out_addr_q == '0 && out_gran_q == '0))
		else $error("non-allocation result carries data");

	a_accept_divides: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (st_q == S_ADIV || st_q == S_FDIV))
		else $error("accepted transaction not started");

endmodule
